FILE: design/liv_pkg.sv
// Package for the layer index validator.
// Holds the entry, config and state-view types and the error codes.
// No dependencies.
package liv_pkg;

   localparam int unsigned ALIGN_MIN = 3;
   localparam int unsigned ALIGN_MAX = 32;
   localparam logic [5:0] ALIGN_RESET = 6'd12;

   typedef enum logic [1:0] {
      CSR_ALIGNMENT_LOG2 = 2'd0,
      CSR_FILE_SIZE      = 2'd1,
      CSR_RESIDENT_BUDGET = 2'd2,
      CSR_DIRECT_IO      = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_ID        = 4'd1,
      ERR_FLAGS     = 4'd2,
      ERR_ZERO_LEN  = 4'd3,
      ERR_SHORT_PAD = 4'd4,
      ERR_OFF_ALIGN = 4'd5,
      ERR_PAD_ALIGN = 4'd6,
      ERR_OVERLAP   = 4'd7,
      ERR_PAST_END  = 4'd8,
      ERR_EARLIER   = 4'd9
   } err_code_type;

   typedef struct packed {
      logic        start_of_index;
      logic [31:0] entry_id;
      logic [31:0] entry_flags;
      logic [63:0] layer_offset;
      logic [63:0] entry_length;
      logic [31:0] padded_length;
   } entry_type;

   typedef struct packed {
      logic [5:0]  alignment_log2;
      logic [63:0] file_size;
      logic [63:0] resident_budget;
      logic        direct_io;
   } cfg_type;

   // state as seen by the entry under check (after an index restart)
   typedef struct packed {
      logic        failed;
      logic [31:0] expected_id;
      logic [63:0] prior_end;
   } check_state_type;

endpackage

FILE: design/liv_csr.sv
// Configuration registers of the layer index validator.
// Depends on liv_pkg.
module liv_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [63:0]              csr_wdata,
   output liv_pkg::cfg_type         cfg
);
   import liv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALIGNMENT_LOG2:  cfg_in.alignment_log2  = csr_wdata[5:0];
            CSR_FILE_SIZE:       cfg_in.file_size       = csr_wdata;
            CSR_RESIDENT_BUDGET: cfg_in.resident_budget = csr_wdata;
            CSR_DIRECT_IO:       cfg_in.direct_io       = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alignment_log2  <= ALIGN_RESET;
         cfg_ff.file_size       <= '0;
         cfg_ff.resident_budget <= '0;
         cfg_ff.direct_io       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/liv_check.sv
// Entry checker: ordered validity checks giving one error code.
// Depends on liv_pkg.
module liv_check (
   input  liv_pkg::entry_type       entry,
   input  liv_pkg::cfg_type         cfg,
   input  liv_pkg::check_state_type view,
   output liv_pkg::err_code_type    code
);
   import liv_pkg::*;

   logic [5:0]  lg;
   logic [32:0] mask;
   logic [64:0] end_sum;
   logic        off_bad;
   logic        pad_bad;

   always_comb begin
      priority if (cfg.alignment_log2 < 6'(ALIGN_MIN)) begin
         lg = 6'(ALIGN_MIN);
      end else if (cfg.alignment_log2 > 6'(ALIGN_MAX)) begin
         lg = 6'(ALIGN_MAX);
      end else begin
         lg = cfg.alignment_log2;
      end
   end

   assign mask    = (33'd1 << lg) - 33'd1;
   assign off_bad = |(entry.layer_offset[32:0] & mask);
   assign pad_bad = |({1'b0, entry.padded_length} & mask);
   assign end_sum = {1'b0, entry.layer_offset} + {33'd0, entry.padded_length};

   always_comb begin
      priority if (view.failed) begin
         code = ERR_EARLIER;
      end else if (entry.entry_id != view.expected_id) begin
         code = ERR_ID;
      end else if (entry.entry_flags != 32'd0) begin
         code = ERR_FLAGS;
      end else if (entry.entry_length == 64'd0) begin
         code = ERR_ZERO_LEN;
      end else if ({32'd0, entry.padded_length} < entry.entry_length) begin
         code = ERR_SHORT_PAD;
      end else if (off_bad) begin
         code = ERR_OFF_ALIGN;
      end else if (pad_bad) begin
         code = ERR_PAD_ALIGN;
      end else if (entry.layer_offset < view.prior_end) begin
         code = ERR_OVERLAP;
      end else if (end_sum > {1'b0, cfg.file_size}) begin
         code = ERR_PAST_END;
      end else begin
         code = ERR_NONE;
      end
   end

endmodule

FILE: design/liv_accum.sv
// Index state and running totals: residency decision, streamed sums,
// largest streamed pad, resident count. Depends on liv_pkg.
module liv_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  liv_pkg::entry_type       entry,
   input  liv_pkg::cfg_type         cfg,
   input  liv_pkg::err_code_type    code,
   output liv_pkg::check_state_type view,
   output logic                     ok,
   output logic                     res,
   output logic [63:0]              payload_prefix,
   output logic [63:0]              resident_bytes,
   output logic [63:0]              streamed_payload,
   output logic [63:0]              streamed_io,
   output logic [31:0]              largest_stream_pad,
   output logic [31:0]              resident_count
);
   import liv_pkg::*;

   logic        failed_ff, failed_in;
   logic [31:0] expected_id_ff, expected_id_in;
   logic [63:0] prior_end_ff, prior_end_in;
   logic        closed_ff, closed_in;
   logic [63:0] resident_sum_ff, resident_sum_in;
   logic [63:0] prefix_sum_ff, prefix_sum_in;
   logic [63:0] stream_payload_ff, stream_payload_in;
   logic [63:0] stream_io_ff, stream_io_in;
   logic [31:0] max_pad_ff, max_pad_in;
   logic [31:0] resident_total_ff, resident_total_in;

   logic        clr;
   logic        closed_cur;
   logic [63:0] resident_cur, prefix_cur, spay_cur, sio_cur;
   logic [31:0] max_cur, total_cur;
   logic [64:0] res_try;
   logic        fits;
   logic [63:0] io_add;

   assign clr          = entry.start_of_index;
   assign view.failed       = clr ? 1'b0  : failed_ff;
   assign view.expected_id  = clr ? '0    : expected_id_ff;
   assign view.prior_end    = clr ? '0    : prior_end_ff;
   assign closed_cur   = clr ? 1'b0 : closed_ff;
   assign resident_cur = clr ? '0 : resident_sum_ff;
   assign prefix_cur   = clr ? '0 : prefix_sum_ff;
   assign spay_cur     = clr ? '0 : stream_payload_ff;
   assign sio_cur      = clr ? '0 : stream_io_ff;
   assign max_cur      = clr ? '0 : max_pad_ff;
   assign total_cur    = clr ? '0 : resident_total_ff;

   assign ok      = (code == ERR_NONE);
   assign res_try = {1'b0, resident_cur} + {1'b0, entry.entry_length};
   assign fits    = (res_try <= {1'b0, cfg.resident_budget});
   assign res     = ok && !closed_cur && fits;
   assign io_add  = cfg.direct_io ? {32'd0, entry.padded_length} : entry.entry_length;

   always_comb begin
      failed_in         = view.failed;
      expected_id_in    = view.expected_id;
      prior_end_in      = view.prior_end;
      closed_in         = closed_cur;
      resident_sum_in   = resident_cur;
      prefix_sum_in     = prefix_cur;
      stream_payload_in = spay_cur;
      stream_io_in      = sio_cur;
      max_pad_in        = max_cur;
      resident_total_in = total_cur;
      if (!ok) begin
         failed_in = 1'b1;
      end else begin
         expected_id_in  = entry.entry_id + 32'd1;
         prior_end_in    = entry.layer_offset + {32'd0, entry.padded_length};
         prefix_sum_in   = prefix_cur + entry.entry_length;
         if (!closed_cur && !fits) begin
            closed_in = 1'b1;
         end
         if (res) begin
            resident_sum_in = res_try[63:0];
            if (total_cur != '1) begin
               resident_total_in = total_cur + 32'd1;
            end
         end else begin
            stream_payload_in = spay_cur + entry.entry_length;
            stream_io_in      = sio_cur + io_add;
            if (entry.padded_length > max_cur) begin
               max_pad_in = entry.padded_length;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff         <= 1'b0;
         expected_id_ff    <= '0;
         prior_end_ff      <= '0;
         closed_ff         <= 1'b0;
         resident_sum_ff   <= '0;
         prefix_sum_ff     <= '0;
         stream_payload_ff <= '0;
         stream_io_ff      <= '0;
         max_pad_ff        <= '0;
         resident_total_ff <= '0;
      end else if (fire) begin
         failed_ff         <= failed_in;
         expected_id_ff    <= expected_id_in;
         prior_end_ff      <= prior_end_in;
         closed_ff         <= closed_in;
         resident_sum_ff   <= resident_sum_in;
         prefix_sum_ff     <= prefix_sum_in;
         stream_payload_ff <= stream_payload_in;
         stream_io_ff      <= stream_io_in;
         max_pad_ff        <= max_pad_in;
         resident_total_ff <= resident_total_in;
      end
   end

   // totals change only when a new result is loaded, so they ride with it
   assign payload_prefix     = prefix_sum_ff;
   assign resident_bytes     = resident_sum_ff;
   assign streamed_payload   = stream_payload_ff;
   assign streamed_io        = stream_io_ff;
   assign largest_stream_pad = max_pad_ff;
   assign resident_count     = resident_total_ff;

endmodule

FILE: design/layer_index_validator.sv
// Layer index validator top level: input register, checker, state, result register.
// An item waits in the input register until the result register is free, then its
// result is registered. Throughput: one item per cycle while rsp_ready is high.
// Reset (synchronous): pipeline empty, state and totals zero, alignment_log2 = 12,
// other config registers zero. Depends on liv_pkg, liv_csr, liv_check, liv_accum.
module layer_index_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_of_index,
   input  logic [31:0] req_entry_id,
   input  logic [31:0] req_entry_flags,
   input  logic [63:0] req_layer_offset,
   input  logic [63:0] req_entry_length,
   input  logic [31:0] req_padded_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_is_resident,
   output logic [63:0] rsp_payload_prefix,
   output logic [63:0] rsp_resident_bytes,
   output logic [63:0] rsp_streamed_payload,
   output logic [63:0] rsp_streamed_io,
   output logic [31:0] rsp_largest_stream_pad,
   output logic [31:0] rsp_resident_count
);
   import liv_pkg::*;

   cfg_type         cfg;
   check_state_type view;
   err_code_type    code;
   entry_type       entry_ff;
   logic            in_vld_ff, in_vld_in;
   logic            out_vld_ff, out_vld_in;
   logic            ok_ff, res_ff;
   err_code_type    code_ff;
   logic            ok, res;
   logic            fire;

   liv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   liv_check u_check (
      .entry (entry_ff),
      .cfg   (cfg),
      .view  (view),
      .code  (code)
   );

   liv_accum u_accum (
      .clock              (clock),
      .reset              (reset),
      .fire               (fire),
      .entry              (entry_ff),
      .cfg                (cfg),
      .code               (code),
      .view               (view),
      .ok                 (ok),
      .res                (res),
      .payload_prefix     (rsp_payload_prefix),
      .resident_bytes     (rsp_resident_bytes),
      .streamed_payload   (rsp_streamed_payload),
      .streamed_io        (rsp_streamed_io),
      .largest_stream_pad (rsp_largest_stream_pad),
      .resident_count     (rsp_resident_count)
   );

   // item moves from the input register to the result register
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (fire) begin
         in_vld_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end
      out_vld_in = out_vld_ff;
      if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (fire) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         entry_ff.start_of_index <= req_start_of_index;
         entry_ff.entry_id       <= req_entry_id;
         entry_ff.entry_flags    <= req_entry_flags;
         entry_ff.layer_offset   <= req_layer_offset;
         entry_ff.entry_length   <= req_entry_length;
         entry_ff.padded_length  <= req_padded_length;
      end
      if (fire) begin
         ok_ff   <= ok;
         res_ff  <= res;
         code_ff <= code;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_accepted    = ok_ff;
   assign rsp_is_resident = res_ff;
   assign rsp_error_code  = code_ff;

endmodule

FILE: dv/layer_index_validator_checker.sv
// Result checker for the layer index validator: mirrors the register writes, predicts each
// entry's verdict and running totals, and compares every result item in order.
// Depends on liv_pkg.
module layer_index_validator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_start_of_index,
   input  logic [31:0] req_entry_id,
   input  logic [31:0] req_entry_flags,
   input  logic [63:0] req_layer_offset,
   input  logic [63:0] req_entry_length,
   input  logic [31:0] req_padded_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic [3:0]  rsp_error_code,
   input  logic        rsp_is_resident,
   input  logic [63:0] rsp_payload_prefix,
   input  logic [63:0] rsp_resident_bytes,
   input  logic [63:0] rsp_streamed_payload,
   input  logic [63:0] rsp_streamed_io,
   input  logic [31:0] rsp_largest_stream_pad,
   input  logic [31:0] rsp_resident_count,
   output int unsigned fail_count,
   output int unsigned pending
);
   import liv_pkg::*;

   typedef struct packed {
      logic         accepted;
      err_code_type error_code;
      logic         is_resident;
      logic [63:0]  payload_prefix;
      logic [63:0]  resident_bytes;
      logic [63:0]  streamed_payload;
      logic [63:0]  streamed_io;
      logic [31:0]  largest_stream_pad;
      logic [31:0]  resident_count;
   } verdict_type;

   typedef struct packed {
      logic [31:0] next_id;
      logic [63:0] last_end;
      logic        latched;
      logic        stream_only;
      logic [63:0] resident_sum;
      logic [63:0] prefix_sum;
      logic [63:0] stream_payload;
      logic [63:0] stream_io;
      logic [31:0] widest_pad;
      logic [31:0] resident_entries;
   } index_state_type;

   cfg_type         cfg_shadow;
   index_state_type idx;
   verdict_type     verdict_q[$];

   function automatic verdict_type validate_entry(input entry_type e);
      verdict_type  v;
      err_code_type code;
      logic [63:0]  mask;
      logic [64:0]  tail;
      int unsigned  lg;
      v = '0;
      if (e.start_of_index) idx = '0;
      lg = cfg_shadow.alignment_log2;
      if (lg < ALIGN_MIN) lg = ALIGN_MIN;
      if (lg > ALIGN_MAX) lg = ALIGN_MAX;
      mask = (64'd1 << lg) - 64'd1;
      // 65-bit end so a carry out of the offset counts as past the end
      tail = {1'b0, e.layer_offset} + {33'd0, e.padded_length};
      if (idx.latched) code = ERR_EARLIER;
      else if (e.entry_id != idx.next_id) code = ERR_ID;
      else if (e.entry_flags != 32'd0) code = ERR_FLAGS;
      else if (e.entry_length == 64'd0) code = ERR_ZERO_LEN;
      else if ({32'd0, e.padded_length} < e.entry_length) code = ERR_SHORT_PAD;
      else if ((e.layer_offset & mask) != 64'd0) code = ERR_OFF_ALIGN;
      else if (({32'd0, e.padded_length} & mask) != 64'd0) code = ERR_PAD_ALIGN;
      else if (e.layer_offset < idx.last_end) code = ERR_OVERLAP;
      else if (tail > {1'b0, cfg_shadow.file_size}) code = ERR_PAST_END;
      else code = ERR_NONE;

      if (code != ERR_NONE) begin
         idx.latched = 1'b1;
      end else begin
         v.accepted = 1'b1;
         idx.next_id = e.entry_id + 32'd1;
         idx.last_end = tail[63:0];
         idx.prefix_sum += e.entry_length;
         if (!idx.stream_only) begin
            if (idx.resident_sum > cfg_shadow.resident_budget ||
                e.entry_length > cfg_shadow.resident_budget - idx.resident_sum)
               idx.stream_only = 1'b1;
            else
               v.is_resident = 1'b1;
         end
         if (v.is_resident) begin
            idx.resident_sum += e.entry_length;
            if (idx.resident_entries != '1) idx.resident_entries++;
         end else begin
            idx.stream_payload += e.entry_length;
            idx.stream_io += cfg_shadow.direct_io ? {32'd0, e.padded_length} : e.entry_length;
            if (e.padded_length > idx.widest_pad) idx.widest_pad = e.padded_length;
         end
      end
      v.error_code = code;
      v.payload_prefix = idx.prefix_sum;
      v.resident_bytes = idx.resident_sum;
      v.streamed_payload = idx.stream_payload;
      v.streamed_io = idx.stream_io;
      v.largest_stream_pad = idx.widest_pad;
      v.resident_count = idx.resident_entries;
      return v;
   endfunction

   function automatic int unsigned field_bad(input string name, input logic [63:0] want,
                                             input logic [63:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      int unsigned errs;
      verdict_type want;
      entry_type   e;
      errs = 0;
      if (reset) begin
         cfg_shadow = '{alignment_log2: ALIGN_RESET, file_size: '0, resident_budget: '0,
                        direct_io: 1'b0};
         idx = '0;
         verdict_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALIGNMENT_LOG2:  cfg_shadow.alignment_log2 = csr_wdata[5:0];
               CSR_FILE_SIZE:       cfg_shadow.file_size = csr_wdata;
               CSR_RESIDENT_BUDGET: cfg_shadow.resident_budget = csr_wdata;
               CSR_DIRECT_IO:       cfg_shadow.direct_io = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: result item with none expected, expected nothing, actual code %0d",
                        $time, rsp_error_code);
               errs++;
            end else begin
               want = verdict_q.pop_front();
               errs += field_bad("accepted", 64'(want.accepted), 64'(rsp_accepted));
               errs += field_bad("error_code", 64'(want.error_code), 64'(rsp_error_code));
               errs += field_bad("is_resident", 64'(want.is_resident), 64'(rsp_is_resident));
               errs += field_bad("payload_prefix", want.payload_prefix, rsp_payload_prefix);
               errs += field_bad("resident_bytes", want.resident_bytes, rsp_resident_bytes);
               errs += field_bad("streamed_payload", want.streamed_payload,
                                 rsp_streamed_payload);
               errs += field_bad("streamed_io", want.streamed_io, rsp_streamed_io);
               errs += field_bad("largest_stream_pad", 64'(want.largest_stream_pad),
                                 64'(rsp_largest_stream_pad));
               errs += field_bad("resident_count", 64'(want.resident_count),
                                 64'(rsp_resident_count));
            end
         end
         if (req_valid && req_ready) begin
            e.start_of_index = req_start_of_index;
            e.entry_id = req_entry_id;
            e.entry_flags = req_entry_flags;
            e.layer_offset = req_layer_offset;
            e.entry_length = req_entry_length;
            e.padded_length = req_padded_length;
            verdict_q.push_back(validate_entry(e));
         end
         pending <= verdict_q.size();
         fail_count <= fail_count + errs;
      end
   end

endmodule

FILE: dv/layer_index_validator_tb.sv
// Testbench top for the layer index validator: clock, reset, register writes, entry
// stimulus and verdict. Depends on liv_pkg, layer_index_validator and
// layer_index_validator_checker.
module layer_index_validator_tb;
   import liv_pkg::*;

   localparam int unsigned STUCK_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned PHASES = 12;
   localparam int unsigned PHASE_ITEMS = 50;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_start_of_index;
   logic [31:0] req_entry_id;
   logic [31:0] req_entry_flags;
   logic [63:0] req_layer_offset;
   logic [63:0] req_entry_length;
   logic [31:0] req_padded_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic [3:0]  rsp_error_code;
   logic        rsp_is_resident;
   logic [63:0] rsp_payload_prefix;
   logic [63:0] rsp_resident_bytes;
   logic [63:0] rsp_streamed_payload;
   logic [63:0] rsp_streamed_io;
   logic [31:0] rsp_largest_stream_pad;
   logic [31:0] rsp_resident_count;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_req = 0;
   int unsigned stuck = 0;
   int unsigned entries_sent = 0;
   int unsigned gen_lg = 12;
   logic [63:0] gen_mask;
   logic [63:0] gen_fsize;

   layer_index_validator dut (.*);
   layer_index_validator_checker entry_audit (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random backpressure, or a long hold-off when requested
   initial begin
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck <= 0;
      end else if (stuck >= STUCK_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   function automatic entry_type mk(input logic s, input logic [31:0] id, input logic [31:0] fl,
                                    input logic [63:0] off, input logic [63:0] len,
                                    input logic [31:0] pad);
      entry_type e;
      e.start_of_index = s;
      e.entry_id = id;
      e.entry_flags = fl;
      e.layer_offset = off;
      e.entry_length = len;
      e.padded_length = pad;
      return e;
   endfunction

   task automatic put_reg(input csr_index_type i, input logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= i;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(input logic [5:0] lg_raw, input logic [63:0] fsize,
                           input logic [63:0] budget, input logic dio);
      put_reg(CSR_ALIGNMENT_LOG2, ({$urandom, $urandom} & ~64'h3F) | {58'd0, lg_raw});
      put_reg(CSR_FILE_SIZE, fsize);
      put_reg(CSR_RESIDENT_BUDGET, budget);
      put_reg(CSR_DIRECT_IO, ({$urandom, $urandom} & ~64'h1) | {63'd0, dio});
      csr_valid <= 1'b0;
      gen_lg = lg_raw;
      if (gen_lg < ALIGN_MIN) gen_lg = ALIGN_MIN;
      if (gen_lg > ALIGN_MAX) gen_lg = ALIGN_MAX;
      gen_mask = (64'd1 << gen_lg) - 64'd1;
      gen_fsize = fsize;
   endtask

   // wait until every expected result has come back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic send(input entry_type e);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_start_of_index <= e.start_of_index;
      req_entry_id <= e.entry_id;
      req_entry_flags <= e.entry_flags;
      req_layer_offset <= e.layer_offset;
      req_entry_length <= e.entry_length;
      req_padded_length <= e.padded_length;
      do @(posedge clock); while (!req_ready);
      entries_sent++;
   endtask

   // one index of well-formed entries, now and then with a single broken field
   task automatic run_index(input int unsigned n);
      entry_type   e;
      logic [63:0] off;
      logic [63:0] len;
      logic [63:0] prev_end;
      logic [63:0] m_top;
      logic [31:0] pad;
      logic [31:0] id;
      id = 32'd0;
      prev_end = 64'd0;
      if ($urandom_range(0, 3) == 0) off = {$urandom, $urandom} & ~gen_mask;
      else off = {32'd0, $urandom_range(0, 4)} << gen_lg;
      for (int i = 0; i < n; i++) begin
         if (gen_lg >= ALIGN_MAX) begin
            pad = 32'd0;
         end else begin
            m_top = 64'hFFFF_FFFF >> gen_lg;
            if (m_top > 4 && $urandom_range(0, 15) != 0) m_top = 4;
            pad = 32'(64'($urandom_range(1, int'(m_top))) << gen_lg);
         end
         if (pad == 32'd0) len = 64'($urandom_range(1, 64));
         else if ($urandom_range(0, 3) == 0) len = {32'd0, pad};
         else len = 64'd1 + ({$urandom, $urandom} % {32'd0, pad});
         e = mk(i == 0, id, 32'd0, off, len, pad);
         if ($urandom_range(0, 7) == 0) begin
            case (err_code_type'($urandom_range(int'(ERR_ID), int'(ERR_PAST_END))))
               ERR_ID:        e.entry_id ^= 32'd1 << $urandom_range(0, 31);
               ERR_FLAGS:     e.entry_flags = $urandom | (32'd1 << $urandom_range(0, 31));
               ERR_ZERO_LEN:  e.entry_length = 64'd0;
               ERR_SHORT_PAD: e.entry_length = $urandom_range(0, 1) ?
                                 {32'd0, pad} + 64'($urandom_range(1, 1000)) :
                                 {$urandom, $urandom} | 64'h8000_0000_0000_0000;
               ERR_OFF_ALIGN: e.layer_offset += 64'($urandom_range(1, 7));
               ERR_PAD_ALIGN: e.padded_length |= 32'd1;
               ERR_OVERLAP:   if (prev_end >= gen_mask + 64'd1)
                                 e.layer_offset = prev_end - gen_mask - 64'd1;
               ERR_PAST_END:  e.layer_offset = gen_fsize & ~gen_mask;
               default: ;
            endcase
         end
         send(e);
         prev_end = e.layer_offset + {32'd0, e.padded_length};
         id = e.entry_id + 32'd1;
         off = prev_end + ({32'd0, $urandom_range(0, 1)} << gen_lg);
      end
   endtask

   initial begin
      logic [5:0]  lg_raw;
      logic [63:0] fsize;
      logic [63:0] budget;
      int unsigned target;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_ALIGNMENT_LOG2;
      csr_wdata <= 64'd0;
      req_valid <= 1'b0;
      req_start_of_index <= 1'b0;
      req_entry_id <= 32'd0;
      req_entry_flags <= 32'd0;
      req_layer_offset <= 64'd0;
      req_entry_length <= 64'd0;
      req_padded_length <= 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed entries, 4 KiB alignment, 1 MiB file
      send_idle_pct = 30;
      recv_idle_pct = 66;
      set_regs(6'd12, 64'h10_0000, 64'd8192, 1'b1);
      send(mk(1'b1, 32'd0, 32'd0, 64'd0, 64'd100, 32'd4096));
      send(mk(1'b0, 32'd1, 32'd0, 64'd4096, 64'd4096, 32'd4096));
      send(mk(1'b0, 32'd2, 32'd0, 64'd8192, 64'd5000, 32'd8192));
      send(mk(1'b0, 32'd3, 32'd0, 64'hF_F000, 64'd1, 32'd4096));
      send(mk(1'b0, 32'hFFFF_FFFF, 32'd0, 64'h10_0000, 64'd1, 32'd4096));
      send(mk(1'b0, 32'd4, 32'd0, 64'h10_0000, 64'd1, 32'd4096));
      send(mk(1'b1, 32'd0, 32'hFFFF_FFFF, 64'd0, 64'd1, 32'd4096));
      send(mk(1'b1, 32'd0, 32'd0, 64'd0, 64'd0, 32'd4096));
      send(mk(1'b1, 32'd0, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4096));
      send(mk(1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 32'd4096));
      send(mk(1'b1, 32'd0, 32'd0, 64'd0, 64'd5, 32'hFFFF_FFFF));
      send(mk(1'b1, 32'd0, 32'd0, 64'd8192, 64'd1, 32'd4096));
      send(mk(1'b0, 32'd1, 32'd0, 64'd4096, 64'd1, 32'd4096));
      send(mk(1'b1, 32'd0, 32'd0, 64'hF_F000, 64'd8192, 32'd8192));
      send(mk(1'b1, 32'd0, 32'd0, 64'd0, 64'd100, 32'd4096));
      // budget drops below what is already resident
      drain();
      put_reg(CSR_RESIDENT_BUDGET, 64'd50);
      csr_valid <= 1'b0;
      send(mk(1'b0, 32'd1, 32'd0, 64'd4096, 64'd10, 32'd4096));
      // top of the 64-bit space: end exactly at 2^64 carries out
      drain();
      put_reg(CSR_FILE_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_valid <= 1'b0;
      send(mk(1'b1, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_E000, 64'd4096, 32'd4096));
      send(mk(1'b0, 32'd1, 32'd0, 64'hFFFF_FFFF_FFFF_F000, 64'd1, 32'd4096));

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph < 4) begin
            send_idle_pct = 30;
            recv_idle_pct = 66;
         end else if (ph < 8) begin
            send_idle_pct = 66;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: set_regs(6'd3, '1, '1, 1'b1);
            1: set_regs(6'd63, '1, 64'd0, 1'b0);
            2: set_regs(6'd0, '1, 64'd0, 1'b1);
            3: set_regs(6'd31, '1, {$urandom, $urandom}, 1'b1);
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: lg_raw = 6'($urandom_range(3, 14));
                  6: lg_raw = 6'($urandom_range(0, 2));
                  7: lg_raw = 6'($urandom_range(33, 63));
                  8: lg_raw = 6'd32;
                  default: lg_raw = 6'($urandom_range(0, 63));
               endcase
               case ($urandom_range(0, 3))
                  0: fsize = '1;
                  1: fsize = {$urandom, $urandom} | 64'h0000_0100_0000_0000;
                  2: fsize = {$urandom, $urandom};
                  default: fsize = {32'd0, $urandom};
               endcase
               case ($urandom_range(0, 3))
                  0: budget = 64'd0;
                  1: budget = 64'($urandom_range(0, 8)) << (lg_raw > 32 ? 32 : lg_raw);
                  2: budget = '1;
                  default: budget = {$urandom, $urandom};
               endcase
               set_regs(lg_raw, fsize, budget, 1'($urandom_range(0, 1)));
            end
         endcase
         if (ph == 9) hold_req++;
         target = entries_sent + PHASE_ITEMS;
         while (entries_sent < target) begin
            if (ph == 2 && entries_sent + PHASE_ITEMS / 2 >= target && pending != 0)
               drain();
            if ($urandom_range(0, 9) == 0)
               send(mk(1'($urandom_range(0, 1)), $urandom, $urandom, {$urandom, $urandom},
                       {$urandom, $urandom}, $urandom));
            else
               run_index($urandom_range(1, 12));
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
